FILE: hdl/imuspd_pkg.sv
// ----------------------------------------------------------------------------
// imuspd_pkg
// Shared constants, types and helpers of the IMU serial packet decoder:
// framing bytes, packet type codes, result kinds and axis scaling.
// ----------------------------------------------------------------------------
`default_nettype none

package imuspd_pkg;

  // framing
  localparam int unsigned PKT_LEN   = 11;
  localparam int unsigned CNT_W     = $clog2(PKT_LEN);
  localparam logic [7:0]  HDR_BYTE  = 8'h55;

  // type byte codes
  localparam logic [7:0] TYPE_ACCEL = 8'h51;
  localparam logic [7:0] TYPE_GYRO  = 8'h52;
  localparam logic [7:0] TYPE_ANGLE = 8'h53;
  localparam logic [7:0] TYPE_MAG   = 8'h54;
  localparam logic [7:0] TYPE_PRESS = 8'h56;

  // fixed-point scale factors
  localparam logic [7:0] GYRO_SCALE  = 8'd125;
  localparam logic [7:0] ANGLE_SCALE = 8'd180;
  localparam logic [7:0] UNIT_SCALE  = 8'd1;

  localparam int unsigned AXIS_W = 24;

  typedef enum logic [2:0] {
    KIND_ACCEL = 3'd0,
    KIND_GYRO  = 3'd1,
    KIND_ANGLE = 3'd2,
    KIND_MAG   = 3'd3,
    KIND_PRESS = 3'd4
  } kind_e;

  // signed 16-bit raw value times a small unsigned constant, exact in 24 bits
  function automatic logic signed [AXIS_W-1:0] axis_scale(input logic [15:0] raw,
                                                          input logic [7:0]  factor);
    logic signed [AXIS_W-1:0] raw_ext;
    logic signed [AXIS_W-1:0] fac_ext;
    raw_ext = $signed({{(AXIS_W-16){raw[15]}}, raw});
    fac_ext = $signed({{(AXIS_W-8){1'b0}}, factor});
    return raw_ext * fac_ext;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/imu_serial_packet_decoder.sv
// ----------------------------------------------------------------------------
// imu_serial_packet_decoder
// Frames 11-byte sensor packets from a serial byte stream, checks the
// running checksum and emits one decoded result per good packet, axes fixed-point scaled.
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  rx      | in        | rx_valid_i / rx_ready_o | rx_byte_i
//  res     | out       | res_valid_o/res_ready_i | packet_kind_o, axis_*_o,
//          |           |                         | temperature_centi_o,
//          |           |                         | pressure_raw_o, altitude_raw_o
//
// One byte is accepted per cycle while rx_ready_o is high; the result of a packet
// appears in the output register in the cycle after its checksum byte is accepted.
// The decode is a single pass from the packet byte registers to the result
// register; the axis scaling uses three 16 by 8 multipliers side by side.
// rx_ready_o drops only while a result waits and the next byte closes a packet.
// Reset clears the byte count, running sum and result valid; no clearing pass.
`default_nettype none

module imu_serial_packet_decoder (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               rx_valid_i,
  output logic                    rx_ready_o,
  input  wire logic [7:0]         rx_byte_i,
  output logic                    res_valid_o,
  input  wire logic               res_ready_i,
  output logic [2:0]              packet_kind_o,
  output logic signed [23:0]      axis_x_o,
  output logic signed [23:0]      axis_y_o,
  output logic signed [23:0]      axis_z_o,
  output logic signed [15:0]      temperature_centi_o,
  output logic signed [31:0]      pressure_raw_o,
  output logic signed [31:0]      altitude_raw_o
);

  localparam int unsigned CntW    = imuspd_pkg::CNT_W;
  localparam int unsigned LastIdx = imuspd_pkg::PKT_LEN - 1;
  localparam logic [CntW-1:0] CntLast = CntW'(LastIdx);

  logic [CntW-1:0] byte_count_q, byte_count_d;
  logic [7:0]      running_sum_q, running_sum_d;
  logic [7:0]      pkt_q [1:LastIdx-1];

  logic rx_acc;
  logic closing;
  logic sum_ok;
  logic type_ok;
  logic emit;

  logic                          res_valid_q, res_valid_d;
  imuspd_pkg::kind_e             kind_d;
  logic [7:0]                    factor;
  logic signed [23:0]            axis_x_d, axis_y_d, axis_z_d;
  logic signed [15:0]            temp_d;
  logic signed [31:0]            press_d, alt_d;

  assign rx_ready_o = !(res_valid_q && !res_ready_i) || (byte_count_q != CntLast);
  assign rx_acc     = rx_valid_i && rx_ready_o;
  assign closing    = (byte_count_q == CntLast);
  assign sum_ok     = (running_sum_q == rx_byte_i);
  assign emit       = rx_acc && closing && sum_ok && type_ok;

  // framing: count and running checksum
  always_comb begin
    byte_count_d  = byte_count_q;
    running_sum_d = running_sum_q;
    if (rx_acc) begin
      if (byte_count_q == '0) begin
        if (rx_byte_i == imuspd_pkg::HDR_BYTE) begin
          byte_count_d  = CntW'(1);
          running_sum_d = rx_byte_i;
        end
      end else if (closing) begin
        byte_count_d  = '0;
        running_sum_d = '0;
      end else begin
        byte_count_d  = byte_count_q + CntW'(1);
        running_sum_d = running_sum_q + rx_byte_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_count_q  <= '0;
      running_sum_q <= '0;
    end else begin
      byte_count_q  <= byte_count_d;
      running_sum_q <= running_sum_d;
    end
  end

  // header byte is never read back, only type and payload are kept
  always_ff @(posedge clk_i) begin
    for (int i = 1; i < LastIdx; i++) begin
      if (rx_acc && byte_count_q == CntW'(i)) begin
        pkt_q[i] <= rx_byte_i;
      end
    end
  end

  // type decode
  always_comb begin
    type_ok = 1'b1;
    kind_d  = imuspd_pkg::KIND_ACCEL;
    factor  = imuspd_pkg::UNIT_SCALE;
    unique case (pkt_q[1])
      imuspd_pkg::TYPE_ACCEL: begin
        kind_d = imuspd_pkg::KIND_ACCEL;
        factor = imuspd_pkg::UNIT_SCALE;
      end
      imuspd_pkg::TYPE_GYRO: begin
        kind_d = imuspd_pkg::KIND_GYRO;
        factor = imuspd_pkg::GYRO_SCALE;
      end
      imuspd_pkg::TYPE_ANGLE: begin
        kind_d = imuspd_pkg::KIND_ANGLE;
        factor = imuspd_pkg::ANGLE_SCALE;
      end
      imuspd_pkg::TYPE_MAG: begin
        kind_d = imuspd_pkg::KIND_MAG;
        factor = imuspd_pkg::UNIT_SCALE;
      end
      imuspd_pkg::TYPE_PRESS: begin
        kind_d = imuspd_pkg::KIND_PRESS;
        factor = imuspd_pkg::UNIT_SCALE;
      end
      default: begin
        type_ok = 1'b0;
      end
    endcase
  end

  // payload decode
  always_comb begin
    axis_x_d = '0;
    axis_y_d = '0;
    axis_z_d = '0;
    temp_d   = '0;
    press_d  = '0;
    alt_d    = '0;
    if (kind_d == imuspd_pkg::KIND_PRESS) begin
      press_d = $signed({pkt_q[5], pkt_q[4], pkt_q[3], pkt_q[2]});
      alt_d   = $signed({pkt_q[9], pkt_q[8], pkt_q[7], pkt_q[6]});
    end else begin
      axis_x_d = imuspd_pkg::axis_scale({pkt_q[3], pkt_q[2]}, factor);
      axis_y_d = imuspd_pkg::axis_scale({pkt_q[5], pkt_q[4]}, factor);
      axis_z_d = imuspd_pkg::axis_scale({pkt_q[7], pkt_q[6]}, factor);
      if (kind_d == imuspd_pkg::KIND_ACCEL) begin
        temp_d = $signed({pkt_q[9], pkt_q[8]});
      end
    end
  end

  // result register
  always_comb begin
    res_valid_d = res_valid_q;
    if (emit) begin
      res_valid_d = 1'b1;
    end else if (res_ready_i) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      packet_kind_o       <= kind_d;
      axis_x_o            <= axis_x_d;
      axis_y_o            <= axis_y_d;
      axis_z_o            <= axis_z_d;
      temperature_centi_o <= temp_d;
      pressure_raw_o      <= press_d;
      altitude_raw_o      <= alt_d;
    end
  end

  assign res_valid_o = res_valid_q;

  // checks
  a_count_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    byte_count_q <= CntLast)
    else $error("byte count past packet end");

  a_stray_dropped : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rx_acc && byte_count_q == '0 && rx_byte_i != imuspd_pkg::HDR_BYTE)
      |=> (byte_count_q == '0))
    else $error("stray byte started a packet");

  a_result_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !$past(res_valid_o)) |-> $past(rx_acc && closing))
    else $error("result without a checksum byte");

  a_press_axes : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && packet_kind_o == imuspd_pkg::KIND_PRESS)
      |-> (axis_x_o == '0 && axis_y_o == '0 && axis_z_o == '0))
    else $error("pressure result with nonzero axes");

  a_temp_accel : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && packet_kind_o != imuspd_pkg::KIND_ACCEL)
      |-> (temperature_centi_o == '0))
    else $error("temperature set outside accel result");

endmodule

`default_nettype wire

FILE: tb/tb_imu_serial_packet_decoder.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_imu_serial_packet_decoder
// Streams serial bytes into the packet decoder: a table of hand-built frames
// (every packet kind, field extremes, stray bytes, headers inside a packet,
// bad checksums, unhandled types), then random frames mixed with noise and
// cut-off frames. A byte-level framer predicts each decoded result, or the table
// gives it; results are checked field by field in order. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb_imu_serial_packet_decoder;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned STREAM_ITEMS = 320;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned PAUSE_EVERY  = 12;
  localparam int          NO_STRAY     = -1;
  localparam int          NUM_ROWS     = 16;

  // type bytes the block must ignore
  localparam logic [7:0] TYPE_BELOW   = 8'h50;
  localparam logic [7:0] TYPE_ABOVE   = 8'h57;
  localparam logic [7:0] TYPE_MAXCODE = 8'hFF;

  localparam logic [7:0] SUM_GOOD = 8'h00;

  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_NONE,
    CHK_VALUE
  } check_e;

  typedef struct packed {
    imuspd_pkg::kind_e kind;
    logic [23:0] ax;
    logic [23:0] ay;
    logic [23:0] az;
    logic [15:0] temp;
    logic [31:0] press;
    logic [31:0] alt;
  } decoded_t;

  typedef struct packed {
    int          stray;
    logic [7:0]  ptype;
    logic [63:0] payload;
    logic [7:0]  sum_flip;
    check_e      check;
    decoded_t    want;
  } frame_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic rx_valid_i;
  logic rx_ready_o;
  logic [7:0] rx_byte_i;
  logic res_valid_o;
  logic res_ready_i = 1'b0;
  logic [2:0] packet_kind_o;
  logic signed [23:0] axis_x_o;
  logic signed [23:0] axis_y_o;
  logic signed [23:0] axis_z_o;
  logic signed [15:0] temperature_centi_o;
  logic signed [31:0] pressure_raw_o;
  logic signed [31:0] altitude_raw_o;

  // payload bytes are little-endian: payload[7:0] is the first byte after the type
  frame_row_t frame_table [NUM_ROWS] = '{
    '{0, imuspd_pkg::TYPE_ACCEL, 64'h0, SUM_GOOD, CHK_VALUE,
      '{imuspd_pkg::KIND_ACCEL, 24'd0, 24'd0, 24'd0, 16'd0, 32'd0, 32'd0}},
    '{255, imuspd_pkg::TYPE_ACCEL, 64'h8000_7FFF_FFFF_0001, SUM_GOOD, CHK_VALUE,
      '{imuspd_pkg::KIND_ACCEL, 24'd1, 24'hFF_FFFF, 24'd32767, 16'h8000, 32'd0, 32'd0}},
    '{NO_STRAY, imuspd_pkg::TYPE_GYRO, 64'hABCD_0001_8000_7FFF, SUM_GOOD, CHK_MODEL, '0},
    '{NO_STRAY, imuspd_pkg::TYPE_GYRO, 64'h0, SUM_GOOD, CHK_VALUE,
      '{imuspd_pkg::KIND_GYRO, 24'd0, 24'd0, 24'd0, 16'd0, 32'd0, 32'd0}},
    '{NO_STRAY, imuspd_pkg::TYPE_ANGLE, 64'hFFFF_FFFF_7FFF_8000, SUM_GOOD, CHK_MODEL, '0},
    '{NO_STRAY, imuspd_pkg::TYPE_ANGLE, 64'h0123_4567_89AB_CDEF, SUM_GOOD, CHK_MODEL, '0},
    // header bytes inside the packet are plain payload
    '{127, imuspd_pkg::TYPE_MAG, 64'h5555_5555_5555_5555, SUM_GOOD, CHK_MODEL, '0},
    '{NO_STRAY, imuspd_pkg::TYPE_MAG, 64'h8000_0001_7FFF_FFFF, SUM_GOOD, CHK_VALUE,
      '{imuspd_pkg::KIND_MAG, 24'hFF_FFFF, 24'd32767, 24'd1, 16'd0, 32'd0, 32'd0}},
    '{NO_STRAY, imuspd_pkg::TYPE_PRESS, 64'hFFFF_FFFF_FFFF_FFFF, SUM_GOOD, CHK_VALUE,
      '{imuspd_pkg::KIND_PRESS, 24'd0, 24'd0, 24'd0, 16'd0,
        32'hFFFF_FFFF, 32'hFFFF_FFFF}},
    '{NO_STRAY, imuspd_pkg::TYPE_PRESS, 64'h8000_0000_7FFF_FFFF, SUM_GOOD, CHK_VALUE,
      '{imuspd_pkg::KIND_PRESS, 24'd0, 24'd0, 24'd0, 16'd0,
        32'h7FFF_FFFF, 32'h8000_0000}},
    '{NO_STRAY, imuspd_pkg::TYPE_ACCEL, 64'h1111_2222_3333_4444, 8'h01, CHK_NONE, '0},
    '{NO_STRAY, imuspd_pkg::TYPE_GYRO, 64'hFFFF_0000_FFFF_0000, 8'h80, CHK_NONE, '0},
    '{NO_STRAY, TYPE_BELOW, 64'h0102_0304_0506_0708, SUM_GOOD, CHK_NONE, '0},
    '{NO_STRAY, imuspd_pkg::HDR_BYTE, 64'h0, SUM_GOOD, CHK_NONE, '0},
    '{NO_STRAY, TYPE_ABOVE, 64'hFEDC_BA98_7654_3210, SUM_GOOD, CHK_NONE, '0},
    '{NO_STRAY, TYPE_MAXCODE, 64'hFFFF_FFFF_FFFF_FFFF, SUM_GOOD, CHK_NONE, '0}
  };

  // framer state of the predictor
  logic [7:0] frm_bytes [10];
  logic [3:0] frm_count = '0;
  logic [7:0] frm_sum   = '0;

  decoded_t pending_q [$];
  check_e   frame_check = CHK_MODEL;
  decoded_t frame_want  = '0;
  bit       calm = 1'b0;

  int unsigned mismatch_cnt  = 0;
  int unsigned results_seen  = 0;
  int unsigned seen_at_draw  = 0;
  int unsigned hold_left     = 0;
  int unsigned cycle_cnt     = 0;
  int unsigned bytes_sent    = 0;
  int unsigned frames_sent   = 0;
  int unsigned kind_hits [5] = '{default: 0};

  imu_serial_packet_decoder DUT (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .rx_valid_i          (rx_valid_i),
    .rx_ready_o          (rx_ready_o),
    .rx_byte_i           (rx_byte_i),
    .res_valid_o         (res_valid_o),
    .res_ready_i         (res_ready_i),
    .packet_kind_o       (packet_kind_o),
    .axis_x_o            (axis_x_o),
    .axis_y_o            (axis_y_o),
    .axis_z_o            (axis_z_o),
    .temperature_centi_o (temperature_centi_o),
    .pressure_raw_o      (pressure_raw_o),
    .altitude_raw_o      (altitude_raw_o)
  );

  always #2 clk_i = ~clk_i;

  function automatic int le_word(input int pos);
    return int'($signed({frm_bytes[pos + 1], frm_bytes[pos]}));
  endfunction

  // feeds one byte into the framer; returns 1 when a packet decodes
  function automatic bit absorb_byte(input logic [7:0] b, output decoded_t d);
    logic [7:0] closing_sum;
    int gain;
    d = '0;
    gain = 0;
    if (frm_count == 0) begin
      if (b != imuspd_pkg::HDR_BYTE) return 1'b0;
      frm_bytes[0] = b;
      frm_sum = b;
      frm_count = 1;
      return 1'b0;
    end
    if (frm_count < imuspd_pkg::PKT_LEN - 1) begin
      frm_bytes[frm_count] = b;
      frm_sum = frm_sum + b;
      frm_count = frm_count + 1;
      return 1'b0;
    end
    frm_count = 0;
    closing_sum = frm_sum;
    frm_sum = '0;
    if (closing_sum != b) return 1'b0;
    case (frm_bytes[1])
      imuspd_pkg::TYPE_ACCEL: begin
        d.kind = imuspd_pkg::KIND_ACCEL;
        gain = imuspd_pkg::UNIT_SCALE;
      end
      imuspd_pkg::TYPE_GYRO: begin
        d.kind = imuspd_pkg::KIND_GYRO;
        gain = imuspd_pkg::GYRO_SCALE;
      end
      imuspd_pkg::TYPE_ANGLE: begin
        d.kind = imuspd_pkg::KIND_ANGLE;
        gain = imuspd_pkg::ANGLE_SCALE;
      end
      imuspd_pkg::TYPE_MAG: begin
        d.kind = imuspd_pkg::KIND_MAG;
        gain = imuspd_pkg::UNIT_SCALE;
      end
      imuspd_pkg::TYPE_PRESS: d.kind = imuspd_pkg::KIND_PRESS;
      default: return 1'b0;
    endcase
    if (d.kind == imuspd_pkg::KIND_PRESS) begin
      d.press = {frm_bytes[5], frm_bytes[4], frm_bytes[3], frm_bytes[2]};
      d.alt   = {frm_bytes[9], frm_bytes[8], frm_bytes[7], frm_bytes[6]};
      return 1'b1;
    end
    d.ax = 24'(le_word(2) * gain);
    d.ay = 24'(le_word(4) * gain);
    d.az = 24'(le_word(6) * gain);
    if (d.kind == imuspd_pkg::KIND_ACCEL) d.temp = {frm_bytes[9], frm_bytes[8]};
    return 1'b1;
  endfunction

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_cnt++;
    end
  endtask

  // both channels seen at the rising edge; requests go in before results come out
  always @(posedge clk_i) begin : watch
    decoded_t d;
    decoded_t w;
    if (rst_ni) begin
      if (rx_valid_i && rx_ready_o) begin
        if (absorb_byte(rx_byte_i, d)) begin
          if (frame_check == CHK_MODEL) pending_q.push_back(d);
          else if (frame_check == CHK_VALUE) pending_q.push_back(frame_want);
        end
      end
      if (res_valid_o && res_ready_i) begin
        results_seen++;
        if (pending_q.size() == 0) begin
          $error("unexpected result: kind %0d with no packet pending", packet_kind_o);
          mismatch_cnt++;
        end else begin
          w = pending_q.pop_front();
          check_field("packet_kind", w.kind, packet_kind_o);
          check_field("axis_x", $signed(w.ax), axis_x_o);
          check_field("axis_y", $signed(w.ay), axis_y_o);
          check_field("axis_z", $signed(w.az), axis_z_o);
          check_field("temperature_centi", $signed(w.temp), temperature_centi_o);
          check_field("pressure_raw", $signed(w.press), pressure_raw_o);
          check_field("altitude_raw", $signed(w.alt), altitude_raw_o);
          if (w.kind <= imuspd_pkg::KIND_PRESS) kind_hits[w.kind]++;
        end
      end
    end
  end

  // result side: after each taken result, draw a random hold-off for the next one
  always @(negedge clk_i) begin
    if (results_seen != seen_at_draw) begin
      seen_at_draw = results_seen;
      hold_left = calm ? 0 : $urandom_range(0, 4);
    end
    if (hold_left != 0) begin
      res_ready_i = 1'b0;
      if (res_valid_o) hold_left--;
    end else begin
      res_ready_i = 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending",
               cycle_cnt, pending_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // called and returns at a falling edge
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 4);
    repeat (gap) begin
      rx_valid_i = 1'b0;
      @(negedge clk_i);
    end
    rx_valid_i = 1'b1;
    rx_byte_i  = b;
    do @(posedge clk_i); while (!rx_ready_o);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_frame(input logic [7:0] ptype, input logic [63:0] payload,
                            input logic [7:0] sum_flip);
    logic [7:0] sum;
    sum = imuspd_pkg::HDR_BYTE + ptype;
    send_byte(imuspd_pkg::HDR_BYTE);
    send_byte(ptype);
    for (int k = 0; k < 8; k++) begin
      sum = sum + payload[8*k +: 8];
      send_byte(payload[8*k +: 8]);
    end
    send_byte(sum ^ sum_flip);
    frames_sent++;
  endtask

  task automatic wait_drained();
    rx_valid_i = 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  initial begin
    int unsigned frame_items;
    int unsigned round;
    int unsigned pick;
    int unsigned cut;
    logic [7:0]  ptype;
    logic [63:0] payload;
    logic [7:0]  flip;

    frame_items = 0;
    round = 0;
    rst_ni = 1'b0;
    rx_valid_i = 1'b0;
    rx_byte_i = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (frame_table[i]) begin
      frame_check = frame_table[i].check;
      frame_want  = frame_table[i].want;
      if (frame_table[i].stray != NO_STRAY) send_byte(8'(frame_table[i].stray));
      send_frame(frame_table[i].ptype, frame_table[i].payload, frame_table[i].sum_flip);
    end
    wait_drained();

    frame_check = CHK_MODEL;
    while (frame_items < STREAM_ITEMS) begin
      calm = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      case ($urandom_range(0, 19))
        0, 1, 2, 3:     ptype = imuspd_pkg::TYPE_ACCEL;
        4, 5, 6, 7:     ptype = imuspd_pkg::TYPE_GYRO;
        8, 9, 10, 11:   ptype = imuspd_pkg::TYPE_ANGLE;
        12, 13, 14, 15: ptype = imuspd_pkg::TYPE_MAG;
        16, 17, 18:     ptype = imuspd_pkg::TYPE_PRESS;
        default:        ptype = 8'($urandom_range(0, 255));
      endcase
      if (pick < 8) begin
        // line noise between packets
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
      end else if (pick < 14) begin
        // packet cut short; the following bytes fill it up
        cut = $urandom_range(0, 7);
        send_byte(imuspd_pkg::HDR_BYTE);
        send_byte(ptype);
        repeat (cut) send_byte(8'($urandom_range(0, 255)));
        frame_items += 2 + cut;
      end else begin
        for (int k = 0; k < 8; k++) begin
          case ($urandom_range(0, 5))
            0:       payload[8*k +: 8] = 8'h00;
            1:       payload[8*k +: 8] = 8'hFF;
            2:       payload[8*k +: 8] = 8'h80;
            3:       payload[8*k +: 8] = 8'h7F;
            default: payload[8*k +: 8] = 8'($urandom_range(0, 255));
          endcase
        end
        flip = (pick < 22) ? 8'(1 << $urandom_range(0, 7)) : SUM_GOOD;
        send_frame(ptype, payload, flip);
        frame_items += imuspd_pkg::PKT_LEN;
      end
      round++;
      if (round % PAUSE_EVERY == 0) wait_drained();
    end

    calm = 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("streamed %0d bytes, %0d complete frames incl. bad checksums and odd types",
             bytes_sent, frames_sent);
    $display("results checked: accel %0d, gyro %0d, angle %0d, magnetic %0d, pressure %0d",
             kind_hits[imuspd_pkg::KIND_ACCEL], kind_hits[imuspd_pkg::KIND_GYRO],
             kind_hits[imuspd_pkg::KIND_ANGLE], kind_hits[imuspd_pkg::KIND_MAG],
             kind_hits[imuspd_pkg::KIND_PRESS]);
    if (mismatch_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
